### hdl/gsp_pkg.sv
// ----------------------------------------------------------------------------
// gsp_pkg
// Shared constants, codes and curve tables for the gas sensor ppm converter.
// ----------------------------------------------------------------------------
`default_nettype none

package gsp_pkg;

  localparam int unsigned ADC_BITS       = 12;
  localparam logic [11:0] ADC_FULL       = 12'((1 << ADC_BITS) - 1);
  localparam int unsigned FAIL_LIMIT_DEF = 5;

  localparam int unsigned CFG_W = 20;

  // input kinds
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FAULT   = 2'd1;
  localparam logic [1:0] ST_PREHEAT = 2'd2;
  localparam logic [1:0] ST_FAILED  = 2'd3;

  // config register indexes
  localparam logic [1:0] REG_SENSOR_TYPE = 2'd0;
  localparam logic [1:0] REG_R0          = 2'd1;
  localparam logic [1:0] REG_RL          = 2'd2;
  localparam logic [1:0] REG_PREHEAT     = 2'd3;

  localparam logic [1:0]       SENSOR_TYPE_RST = 2'd0;
  localparam logic [CFG_W-1:0] R0_RST          = 20'd2560;
  localparam logic [CFG_W-1:0] RL_RST          = 20'd2560;
  localparam logic [CFG_W-1:0] PREHEAT_RST     = 20'd20000;

  localparam logic [29:0] LN2_Q30  = 30'd744261118;
  localparam logic [24:0] PPM_MAX  = 25'd25600000;
  localparam logic [9:0]  THOUSAND = 10'd1000;
  localparam int unsigned EXP_TERMS = 20;

  // divider geometry
  localparam int unsigned DIV_W  = 48;
  localparam int unsigned DIV_DW = 10;

  // curve coefficient a, scaled by 1000
  function automatic logic [19:0] curve_a_milli(input logic [1:0] t);
    logic [19:0] r;
    case (t)
      2'd0:    r = 20'd987990;
      2'd1:    r = 20'd99042;
      2'd2:    r = 20'd110470;
      default: r = 20'd1000;
    endcase
    return r;
  endfunction

  // magnitude of exponent b, scaled by 1000; all curves have negative b
  function automatic logic [11:0] curve_b_mag(input logic [1:0] t);
    logic [11:0] r;
    case (t)
      2'd0:    r = 12'd2162;
      2'd1:    r = 12'd1518;
      2'd2:    r = 12'd2862;
      default: r = 12'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/gsp_div.sv
// ----------------------------------------------------------------------------
// gsp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gsp_div #(
  parameter int unsigned W  = 48,
  parameter int unsigned DW = 10
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [W-1:0]  dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic               busy_o,
  output logic [W-1:0]       quotient_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW:0]   rem_sh;
  logic          take;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    rem_sh = {rem_q, quo_q[W-1]};
    take   = rem_sh >= {1'b0, divisor_i};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(W);
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = take ? DW'(rem_sh - {1'b0, divisor_i}) : rem_sh[DW-1:0];
      quo_d = {quo_q[W-2:0], take};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

### hdl/gas_sensor_ppm_converter.sv
// ----------------------------------------------------------------------------
// gas_sensor_ppm_converter
// MQ-series power-law ppm converter with warm-up gating and fault latch.
// ----------------------------------------------------------------------------
// Ticks and restarts are handled in the idle state. A refused or pre-failed
// read goes straight to the done state, which holds the input off until the
// output is free and then registers its word. A converted read runs on one
// shared multiplier and one bit-serial divider: two products, four base-2
// logs, a divide by 1000 done as multiply steps with a reciprocal, then up to
// 20 series terms of one multiply plus a divide each. The input is not ready
// while a read converts or its result waits.
`default_nettype none

module gas_sensor_ppm_converter #(
  parameter int unsigned FAIL_LIMIT = gsp_pkg::FAIL_LIMIT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [11:0] adc_sample_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_code_o,
  output logic [24:0]      ppm_value_o,
  output logic [7:0]       failures_seen_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [19:0] cfg_data_i
);

  import gsp_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_NUM   = 4'd1;
  localparam logic [3:0] S_DEN   = 4'd2;
  localparam logic [3:0] S_LNORM = 4'd3;
  localparam logic [3:0] S_LSQ   = 4'd4;
  localparam logic [3:0] S_BMUL  = 4'd5;
  localparam logic [3:0] S_BDIV  = 4'd6;
  localparam logic [3:0] S_EXPX  = 4'd7;
  localparam logic [3:0] S_TMUL  = 4'd8;
  localparam logic [3:0] S_TDIV  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;
  localparam logic [3:0] S_BQA   = 4'd12;
  localparam logic [3:0] S_BR1   = 4'd13;
  localparam logic [3:0] S_BREC  = 4'd14;

  localparam logic signed [39:0] E_EIGHT = 40'sd8 <<< 30;
  localparam logic signed [39:0] E_HI    = 40'sd26 <<< 30;
  localparam logic signed [39:0] E_LO    = -(40'sd2 <<< 30);
  localparam logic signed [39:0] E_BIAS  = 40'sd2 <<< 30;

  // 2^24 = 16777 * 1000 + 216; ceil(2^41 / 1000) is exact below 2^31
  localparam logic [31:0] P24_QUO    = 32'd16777;
  localparam logic [31:0] P24_REM    = 32'd216;
  localparam logic [31:0] RECIP_1000 = 32'd2199023256;

  // config
  logic [1:0]       type_q;
  logic [CFG_W-1:0] r0_q, rl_q, preheat_q;

  // block state
  logic [19:0] warm_q, warm_d;
  logic [7:0]  fc_q, fc_d;
  logic        fault_q, fault_d;

  // sequencer
  logic [3:0]  state_q, state_d;
  logic [1:0]  res_q, res_d;
  logic [24:0] rppm_q, rppm_d;
  logic [11:0] raw_q, raw_d;
  logic [31:0] num_q, num_d, den_q, den_d;
  logic [1:0]  j_q, j_d;
  logic [4:0]  it_q, it_d;
  logic [4:0]  n_q, n_d;
  logic [30:0] m_q, m_d;
  logic [29:0] frac_q, frac_d;
  logic signed [36:0] lr_q, lr_d, ea_q, ea_d;
  logic        neg_q, neg_d;
  logic [46:0] p_q, p_d;
  logic [37:0] qa_q, qa_d;
  logic [30:0] r1_q, r1_d;
  logic [37:0] qd_q, qd_d;
  logic [4:0]  k_q, k_d;
  logic [29:0] f_q, f_d;
  logic [29:0] x_q, x_d;
  logic [30:0] term_q, term_d;
  logic [31:0] sum_q, sum_d;
  logic [4:0]  nt_q, nt_d;

  // output word
  logic        ov_q, ov_d;
  logic [1:0]  ost_q, ost_d;
  logic [24:0] oppm_q, oppm_d;
  logic [7:0]  ofs_q, ofs_d;

  // shared multiplier
  logic [35:0] mul_a;
  logic [31:0] mul_b;
  logic [67:0] prod;

  // divider
  logic            div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic [DIV_DW-1:0] div_divisor;
  logic            div_busy;
  logic [DIV_W-1:0]  div_quo;

  logic        in_acc, out_free, pre_fail;
  logic [31:0] log_x;
  logic [4:0]  msb;
  logic [61:0] norm;
  logic [31:0] sq;
  logic        sq_bit;
  logic [29:0] frac_nx;
  logic signed [36:0] logv;
  logic [35:0] lr_mag;
  logic signed [39:0] qs, e_val, u_val;
  logic [58:0] shifted, val;
  logic [30:0] t_new;
  logic [7:0]  fc_inc;

  gsp_div #(.W(DIV_W), .DW(DIV_DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !ov_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q    <= SENSOR_TYPE_RST;
      r0_q      <= R0_RST;
      rl_q      <= RL_RST;
      preheat_q <= PREHEAT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SENSOR_TYPE: type_q    <= cfg_data_i[1:0];
        REG_R0:          r0_q      <= cfg_data_i;
        REG_RL:          rl_q      <= cfg_data_i;
        REG_PREHEAT:     preheat_q <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_NUM:  begin mul_a = 36'(rl_q);   mul_b = 32'(ADC_FULL - raw_q); end
      S_DEN:  begin mul_a = 36'(raw_q);  mul_b = 32'(r0_q); end
      S_LSQ:  begin mul_a = 36'(m_q);    mul_b = 32'(m_q); end
      S_BMUL: begin mul_a = lr_mag;      mul_b = 32'(curve_b_mag(type_q)); end
      S_BQA:  begin mul_a = 36'(p_q[46:24]); mul_b = P24_QUO; end
      S_BR1:  begin mul_a = 36'(p_q[46:24]); mul_b = P24_REM; end
      S_BREC: begin mul_a = 36'(r1_q);   mul_b = RECIP_1000; end
      S_EXPX: begin mul_a = 36'(f_q);    mul_b = 32'(LN2_Q30); end
      S_TMUL: begin mul_a = 36'(term_q); mul_b = 32'(x_q); end
      default: ;
    endcase
  end
  assign prod = 68'(mul_a) * 68'(mul_b);

  assign div_start    = (state_q == S_TMUL);
  assign div_dividend = DIV_W'(prod[61:30]);
  assign div_divisor  = DIV_DW'(nt_q);

  // log normalization
  always_comb begin
    case (j_q)
      2'd0:    log_x = num_q;
      2'd1:    log_x = den_q;
      2'd2:    log_x = 32'(curve_a_milli(type_q));
      default: log_x = 32'(THOUSAND);
    endcase
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (log_x[i]) msb = 5'(i);
    end
  end
  assign norm = ({30'd0, log_x} << 30) >> msb;

  assign sq      = prod[61:30];
  assign sq_bit  = sq[31];
  assign frac_nx = {frac_q[28:0], sq_bit};
  assign logv    = $signed({2'b00, n_q, frac_nx});

  assign lr_mag = lr_q[36] ? 36'(-lr_q) : 36'(lr_q);
  assign qs     = $signed({2'b00, qd_q});
  assign e_val  = 40'(ea_q) + E_EIGHT + (neg_q ? -qs : qs);
  assign u_val  = e_val + E_BIAS;

  assign shifted = 59'(sum_q) << k_q;
  assign val     = (shifted + 59'h80000000) >> 32;
  assign t_new   = div_quo[30:0];
  assign fc_inc  = (fc_q == 8'hFF) ? fc_q : fc_q + 8'd1;

  assign pre_fail = (type_q > 2'd2) || (r0_q == '0) || (rl_q == '0)
                  || (21'(adc_sample_i) * 21'd330 <= 21'(ADC_FULL))
                  || (adc_sample_i >= ADC_FULL);

  always_comb begin
    state_d = state_q;
    warm_d  = warm_q;
    fc_d    = fc_q;
    fault_d = fault_q;
    res_d   = res_q;
    rppm_d  = rppm_q;
    raw_d   = raw_q;
    num_d   = num_q;
    den_d   = den_q;
    j_d     = j_q;
    it_d    = it_q;
    n_d     = n_q;
    m_d     = m_q;
    frac_d  = frac_q;
    lr_d    = lr_q;
    ea_d    = ea_q;
    neg_d   = neg_q;
    p_d     = p_q;
    qa_d    = qa_q;
    r1_d    = r1_q;
    qd_d    = qd_q;
    k_d     = k_q;
    f_d     = f_q;
    x_d     = x_q;
    term_d  = term_q;
    sum_d   = sum_q;
    nt_d    = nt_q;
    ov_d    = ov_q && !out_ready_i;
    ost_d   = ost_q;
    oppm_d  = oppm_q;
    ofs_d   = ofs_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (kind_i)
            KIND_TICK: begin
              if (warm_q != 20'hFFFFF) warm_d = warm_q + 20'd1;
            end
            KIND_RESTART: begin
              warm_d  = '0;
              fc_d    = '0;
              fault_d = 1'b0;
            end
            KIND_READ: begin
              raw_d   = adc_sample_i;
              rppm_d  = '0;
              state_d = S_DONE;
              if (fault_q)                 res_d = ST_FAULT;
              else if (warm_q < preheat_q) res_d = ST_PREHEAT;
              else if (pre_fail)           res_d = ST_FAILED;
              else                         state_d = S_NUM;
            end
            default: ;
          endcase
        end
      end
      S_NUM: begin
        num_d   = prod[31:0];
        state_d = S_DEN;
      end
      S_DEN: begin
        den_d   = prod[31:0];
        j_d     = 2'd0;
        state_d = S_LNORM;
      end
      S_LNORM: begin
        n_d     = msb;
        m_d     = norm[30:0];
        frac_d  = '0;
        it_d    = '0;
        state_d = S_LSQ;
      end
      S_LSQ: begin
        m_d    = sq_bit ? sq[31:1] : sq[30:0];
        frac_d = frac_nx;
        it_d   = it_q + 5'd1;
        if (it_q == 5'd29) begin
          case (j_q)
            2'd0:    lr_d = logv;
            2'd1:    lr_d = lr_q - logv;
            2'd2:    ea_d = logv;
            default: ea_d = ea_q - logv;
          endcase
          j_d     = j_q + 2'd1;
          state_d = (j_q == 2'd3) ? S_BMUL : S_LNORM;
        end
      end
      S_BMUL: begin
        // b is negative, so the product sign is the inverse of lr's sign
        neg_d   = !lr_q[36];
        p_d     = prod[46:0];
        state_d = S_BQA;
      end
      // split p = hi * 2^24 + lo; p / 1000 = hi * 16777 + (hi * 216 + lo) / 1000
      S_BQA: begin
        qa_d    = prod[37:0];
        state_d = S_BR1;
      end
      S_BR1: begin
        r1_d    = prod[30:0] + {7'd0, p_q[23:0]};
        state_d = S_BREC;
      end
      S_BREC: begin
        qd_d    = qa_q + 38'(prod[62:41]);
        state_d = S_BDIV;
      end
      S_BDIV: begin
        if (e_val >= E_HI) begin
          res_d   = ST_FAILED;
          state_d = S_DONE;
        end else if (e_val < E_LO) begin
          res_d   = ST_OK;
          rppm_d  = '0;
          state_d = S_DONE;
        end else begin
          k_d     = u_val[34:30];
          f_d     = u_val[29:0];
          state_d = S_EXPX;
        end
      end
      S_EXPX: begin
        x_d     = prod[59:30];
        term_d  = 31'd1 << 30;
        sum_d   = 32'd1 << 30;
        nt_d    = 5'd1;
        state_d = S_TMUL;
      end
      S_TMUL: begin
        state_d = S_TDIV;
      end
      S_TDIV: begin
        if (!div_busy) begin
          if (t_new == '0) begin
            state_d = S_FIN;
          end else begin
            term_d = t_new;
            sum_d  = sum_q + 32'(t_new);
            nt_d   = nt_q + 5'd1;
            state_d = (nt_q == 5'(EXP_TERMS)) ? S_FIN : S_TMUL;
          end
        end
      end
      S_FIN: begin
        if (val > 59'(PPM_MAX)) begin
          res_d = ST_FAILED;
        end else begin
          res_d  = ST_OK;
          rppm_d = val[24:0];
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ov_d    = 1'b1;
          oppm_d  = '0;
          ofs_d   = fc_q;
          state_d = S_IDLE;
          case (res_q)
            ST_OK: begin
              ost_d  = ST_OK;
              oppm_d = rppm_q;
              fc_d   = '0;
              ofs_d  = '0;
            end
            ST_FAULT:   ost_d = ST_FAULT;
            ST_PREHEAT: ost_d = ST_PREHEAT;
            default: begin
              fc_d  = fc_inc;
              ofs_d = fc_inc;
              if (fc_inc > 8'(FAIL_LIMIT)) begin
                fault_d = 1'b1;
                ost_d   = ST_FAULT;
              end else begin
                ost_d = ST_FAILED;
              end
            end
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      warm_q  <= '0;
      fc_q    <= '0;
      fault_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      warm_q  <= warm_d;
      fc_q    <= fc_d;
      fault_q <= fault_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    rppm_q <= rppm_d;
    raw_q  <= raw_d;
    num_q  <= num_d;
    den_q  <= den_d;
    j_q    <= j_d;
    it_q   <= it_d;
    n_q    <= n_d;
    m_q    <= m_d;
    frac_q <= frac_d;
    lr_q   <= lr_d;
    ea_q   <= ea_d;
    neg_q  <= neg_d;
    p_q    <= p_d;
    qa_q   <= qa_d;
    r1_q   <= r1_d;
    qd_q   <= qd_d;
    k_q    <= k_d;
    f_q    <= f_d;
    x_q    <= x_d;
    term_q <= term_d;
    sum_q  <= sum_d;
    nt_q   <= nt_d;
    ost_q  <= ost_d;
    oppm_q <= oppm_d;
    ofs_q  <= ofs_d;
  end

  assign out_valid_o     = ov_q;
  assign status_code_o   = ost_q;
  assign ppm_value_o     = oppm_q;
  assign failures_seen_o = ofs_q;

endmodule

`default_nettype wire
